// File: design/fbes_pkg.sv
`default_nettype none
package fbes_pkg;

  localparam int SAMPLE_W = 24;
  localparam int ACC_W    = 32;   // Q24.8
  localparam int FRAC_W   = 8;
  localparam int WEIGHT_W = 17;
  localparam int PROD_W   = 51;

  localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'h10000;

  // one classified input beat on its way from front to back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       is_last;
    logic                       drop;
  } entry_t;

endpackage
`default_nettype wire

// File: design/fbes_front.sv
`default_nettype none
module fbes_front #(
  parameter int MAX_LEN = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic signed [fbes_pkg::SAMPLE_W-1:0] sample,
  input  wire logic                                 is_last,
  input  wire logic                                 q_full,
  output logic                                      q_push,
  output fbes_pkg::entry_t                          q_entry
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);

  logic [CNT_W-1:0] count;
  logic             drop;

  assign full   = q_full;
  assign q_push = push && !q_full;
  assign drop   = (count == CNT_W'(MAX_LEN));

  assign q_entry.sample  = sample;
  assign q_entry.is_last = is_last;
  assign q_entry.drop    = drop;

  // mirrors the store fill level so that overflow is decided at the door
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (q_push) begin
      if (is_last) begin
        count <= '0;
      end else if (!drop) begin
        count <= count + CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: design/fbes_queue.sv
`default_nettype none
module fbes_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire fbes_pkg::entry_t wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output fbes_pkg::entry_t      rd_data,
  output logic                  empty
);

  localparam int Q_DEPTH = 4;
  localparam int PTR_W   = $clog2(Q_DEPTH);
  localparam int LVL_W   = $clog2(Q_DEPTH + 1);

  fbes_pkg::entry_t mem [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [LVL_W-1:0] level;
  logic             do_wr;
  logic             do_rd;

  assign full    = (level == LVL_W'(Q_DEPTH));
  assign empty   = (level == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        level <= level + LVL_W'(1);
      end else if (do_rd && !do_wr) begin
        level <= level - LVL_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: design/fbes_back.sv
`default_nettype none
module fbes_back #(
  parameter int MAX_LEN = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 weight_we,
  input  wire logic [fbes_pkg::WEIGHT_W-1:0]        weight_data,
  input  wire logic                                 q_empty,
  input  wire fbes_pkg::entry_t                     q_entry,
  output logic                                      q_pop,
  input  wire logic                                 pop,
  output logic                                      empty,
  output logic signed [fbes_pkg::SAMPLE_W-1:0]      smoothed,
  output logic                                      end_of_run,
  output logic                                      truncated
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int SW    = fbes_pkg::SAMPLE_W;
  localparam int AW    = fbes_pkg::ACC_W;
  localparam int PW    = fbes_pkg::PROD_W;
  localparam int FW    = fbes_pkg::FRAC_W;
  localparam int SUM_W = AW + 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FMUL,
    ST_FADD,
    ST_BINIT,
    ST_BRD,
    ST_BMUL,
    ST_BADD,
    ST_ORD,
    ST_OCALC
  } state_t;

  state_t state;

  logic [fbes_pkg::WEIGHT_W-1:0] weight;
  logic [fbes_pkg::WEIGHT_W-1:0] w_eff;

  logic [CNT_W-1:0]     count;
  logic                 ovf;
  logic                 last_pend;
  logic [IDX_W-1:0]     idx;
  logic signed [AW-1:0] prev;
  logic signed [AW-1:0] x_last;
  logic signed [AW-1:0] x_reg;
  logic signed [PW-1:0] prod;
  logic                 out_valid;

  logic signed [SW-1:0] sample_mem [MAX_LEN];
  logic signed [AW-1:0] fwd_mem    [MAX_LEN];
  logic signed [AW-1:0] bwd_mem    [MAX_LEN];
  logic signed [SW-1:0] smp_rd;
  logic signed [AW-1:0] fwd_rd;
  logic signed [AW-1:0] bwd_rd;

  logic                 take;
  logic signed [AW-1:0] x8_in;
  logic signed [AW-1:0] x_op;
  logic signed [AW:0]   diff;
  logic signed [PW-1:0] x_ext;
  logic signed [PW-1:0] blend_sum;
  logic signed [AW-1:0] blend;
  logic [IDX_W-1:0]     wr_idx;
  logic [IDX_W-1:0]     bidx;
  logic [IDX_W-1:0]     idx_dn;
  logic                 smp_we;
  logic                 fwd_we;
  logic signed [AW-1:0] fwd_wdata;
  logic                 bwd_we;
  logic [IDX_W-1:0]     bwd_waddr;
  logic signed [AW-1:0] bwd_wdata;
  logic signed [SUM_W-1:0] osum;
  logic signed [SW:0]      oshift;
  logic signed [SW-1:0]    osat;
  logic                 out_free;
  logic                 out_last;

  assign w_eff = (weight > fbes_pkg::ONE_Q16) ? fbes_pkg::ONE_Q16 : weight;

  assign q_pop  = (state == ST_IDLE) && !q_empty;
  assign take   = q_pop;
  assign x8_in  = $signed({q_entry.sample, {FW{1'b0}}});
  assign wr_idx = count[IDX_W-1:0];
  assign bidx   = IDX_W'(count - CNT_W'(1));
  assign idx_dn = idx - IDX_W'(1);

  // w*prev + (1-w)*x == x + w*(prev - x), one multiply per step
  assign x_op      = (state == ST_BMUL) ? $signed({smp_rd, {FW{1'b0}}}) : x_reg;
  assign diff      = {prev[AW-1], prev} - {x_op[AW-1], x_op};
  assign x_ext     = {{(PW-AW){x_reg[AW-1]}}, x_reg};
  assign blend_sum = (x_ext <<< 16) + prod + PW'(32768);
  assign blend     = blend_sum[AW+15:16];

  assign smp_we    = take && !q_entry.drop;
  assign fwd_we    = (take && !q_entry.drop && (count == '0)) || (state == ST_FADD);
  assign fwd_wdata = (state == ST_FADD) ? blend : x8_in;
  assign bwd_we    = (state == ST_BINIT) || (state == ST_BADD);
  assign bwd_waddr = (state == ST_BINIT) ? bidx : idx_dn;
  assign bwd_wdata = (state == ST_BINIT) ? x_last : blend;

  assign osum   = {{2{fwd_rd[AW-1]}}, fwd_rd} + {{2{bwd_rd[AW-1]}}, bwd_rd} + SUM_W'(256);
  assign oshift = osum[SW+9:9];
  always_comb begin
    if (oshift[SW] != oshift[SW-1]) begin
      osat = oshift[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      osat = oshift[SW-1:0];
    end
  end

  assign out_free = !out_valid || pop;
  assign out_last = ((CNT_W'(idx) + CNT_W'(1)) == count);
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (smp_we) begin
      sample_mem[wr_idx] <= q_entry.sample;
    end
    if (state == ST_BRD) begin
      smp_rd <= sample_mem[idx_dn];
    end
  end

  always_ff @(posedge clk) begin
    if (fwd_we) begin
      fwd_mem[wr_idx] <= fwd_wdata;
    end
    if (state == ST_ORD) begin
      fwd_rd <= fwd_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (bwd_we) begin
      bwd_mem[bwd_waddr] <= bwd_wdata;
    end
    if (state == ST_ORD) begin
      bwd_rd <= bwd_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    prod <= diff * $signed({1'b0, w_eff});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= fbes_pkg::WEIGHT_W'(32768);
    end else if (weight_we) begin
      weight <= weight_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // OCALC refills the output register on its own
      if (pop && out_valid && (state != ST_OCALC)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take) begin
            if (q_entry.drop) begin
              ovf <= 1'b1;
              if (q_entry.is_last) begin
                state <= ST_BINIT;
              end
            end else if (count == '0) begin
              prev   <= x8_in;
              x_last <= x8_in;
              count  <= CNT_W'(1);
              if (q_entry.is_last) begin
                state <= ST_BINIT;
              end
            end else begin
              x_reg     <= x8_in;
              x_last    <= x8_in;
              last_pend <= q_entry.is_last;
              state     <= ST_FMUL;
            end
          end
        end
        ST_FMUL: begin
          state <= ST_FADD;
        end
        ST_FADD: begin
          prev  <= blend;
          count <= count + CNT_W'(1);
          state <= last_pend ? ST_BINIT : ST_IDLE;
        end
        ST_BINIT: begin
          prev  <= x_last;
          idx   <= bidx;
          state <= (bidx == '0) ? ST_ORD : ST_BRD;
        end
        ST_BRD: begin
          state <= ST_BMUL;
        end
        ST_BMUL: begin
          x_reg <= x_op;
          state <= ST_BADD;
        end
        ST_BADD: begin
          prev  <= blend;
          idx   <= idx_dn;
          state <= (idx_dn == '0) ? ST_ORD : ST_BRD;
        end
        ST_ORD: begin
          state <= ST_OCALC;
        end
        ST_OCALC: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            smoothed   <= osat;
            end_of_run <= out_last;
            truncated  <= ovf;
            if (out_last) begin
              count <= '0;
              ovf   <= 1'b0;
              state <= ST_IDLE;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= ST_ORD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/forward_backward_ema_smoother.sv
// Forward-backward exponential smoother. Samples of one spectrum are pushed
// one beat at a time, the final one marked by is_last; after it the block
// emits one smoothed result per stored sample, in order, the final one marked
// by end_of_run. Up to MAX_LEN samples are kept; later ones are dropped and
// every result of that spectrum shows truncated. In the engine the first
// sample of a spectrum is stored at once, each further one passes FMUL and
// FADD (shared multiplier, one blend step at a time); the backward pass runs
// BINIT, then BRD, BMUL and BADD per step, and readout ORD and OCALC per
// result; BRD and ORD wait on registered reads of the sample and smoothing
// memories. A 4-beat queue lets the input keep taking beats while the
// engine is busy. weight_data is a Q1.16 weight (65536 = 1.0, larger values
// act as 1.0), reset to 0.5; write it only while no spectrum is in flight.
`default_nettype none
module forward_backward_ema_smoother #(
  parameter int MAX_LEN = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic signed [fbes_pkg::SAMPLE_W-1:0] sample,
  input  wire logic                                 is_last,
  input  wire logic                                 pop,
  output logic                                      empty,
  output logic signed [fbes_pkg::SAMPLE_W-1:0]      smoothed,
  output logic                                      end_of_run,
  output logic                                      truncated,
  input  wire logic                                 weight_we,
  input  wire logic [fbes_pkg::WEIGHT_W-1:0]        weight_data
);

  fbes_pkg::entry_t q_in;
  fbes_pkg::entry_t q_out;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;

  fbes_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .sample  (sample),
    .is_last (is_last),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_in)
  );

  fbes_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_in),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_out),
    .empty   (q_empty)
  );

  fbes_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .weight_we   (weight_we),
    .weight_data (weight_data),
    .q_empty     (q_empty),
    .q_entry     (q_out),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .smoothed    (smoothed),
    .end_of_run  (end_of_run),
    .truncated   (truncated)
  );

endmodule
`default_nettype wire

// File: design/fbes_checker.sv
`default_nettype none
module fbes_props (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        push,
  input wire logic        full,
  input wire logic        pop,
  input wire logic        empty,
  input wire logic [23:0] smoothed,
  input wire logic        end_of_run,
  input wire logic        truncated
);

  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queue not clear after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(smoothed) && $stable(end_of_run)
                          && $stable(truncated)))
    else $error("waiting result changed");

  a_result_known: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !$isunknown({smoothed, end_of_run, truncated}))
    else $error("result beat carries unknown bits");

endmodule

bind forward_backward_ema_smoother fbes_props u_fbes_props (
  .clk        (clk),
  .rst        (rst),
  .push       (push),
  .full       (full),
  .pop        (pop),
  .empty      (empty),
  .smoothed   (smoothed),
  .end_of_run (end_of_run),
  .truncated  (truncated)
);
`default_nettype wire
